// File: hw/rtl/slp_pkg.sv
package slp_pkg;

   localparam int SampleW  = 32;
   localparam int GainW    = 17;
   localparam int CoefW    = 16;
   localparam int IdxW     = 2;
   localparam int PcW      = 4;
   localparam int DivSteps = 16;
   localparam int CntW     = 4;
   localparam int ProdW    = 50;

   localparam logic [GainW-1:0] GAIN_UNITY = 17'h10000;
   localparam logic [CoefW-1:0] LEVEL_MIN  = 16'd19661;
   localparam logic [CoefW-1:0] LEVEL_MAX  = 16'd62259;
   localparam logic [CoefW-1:0] REL_RESET  = 16'd65503;

   localparam logic [IdxW-1:0] REG_LIMITER_ON    = 2'd0;
   localparam logic [IdxW-1:0] REG_LIMIT_LEVEL   = 2'd1;
   localparam logic [IdxW-1:0] REG_RELEASE_COEFF = 2'd2;

   typedef logic [PcW-1:0] pc_type;

   localparam pc_type PC_WAIT   = 4'd0;
   localparam pc_type PC_PEAK   = 4'd1;
   localparam pc_type PC_CMP    = 4'd2;
   localparam pc_type PC_DIV    = 4'd3;
   localparam pc_type PC_REL    = 4'd4;
   localparam pc_type PC_TGT    = 4'd5;
   localparam pc_type PC_WB     = 4'd6;
   localparam pc_type PC_ATTACK = 4'd7;
   localparam pc_type PC_SCALE  = 4'd8;
   localparam pc_type PC_SCALER = 4'd9;
   localparam pc_type PC_EMIT   = 4'd10;
   localparam pc_type PC_RETRY  = 4'd11;
   localparam pc_type PC_UNITY  = 4'd12;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_PEAK,
      OP_DIV_STEP,
      OP_MUL_REL,
      OP_MUL_TGT,
      OP_REL_WB,
      OP_ATTACK,
      OP_SET_UNITY,
      OP_SCALE_L,
      OP_SCALE_R,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_INPUT,
      C_OFF,
      C_NO_EXCEED,
      C_DIV_MORE,
      C_ATTACK,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   typedef struct packed {
      logic in_valid;
      logic limiter_off;
      logic no_exceed;
      logic div_more;
      logic attack;
      logic out_free;
   } status_type;

   // The control program. A taken condition jumps to the target, otherwise the
   // step counter moves on by one.
   function automatic uword_type ucode(input pc_type pc);
      uword_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: PC_WAIT};
      case (pc)
         PC_WAIT:   w = '{op: OP_LOAD,      cond: C_NO_INPUT,  target: PC_WAIT};
         PC_PEAK:   w = '{op: OP_PEAK,      cond: C_OFF,       target: PC_UNITY};
         PC_CMP:    w = '{op: OP_NOP,       cond: C_NO_EXCEED, target: PC_REL};
         PC_DIV:    w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,  target: PC_DIV};
         PC_REL:    w = '{op: OP_MUL_REL,   cond: C_ATTACK,    target: PC_ATTACK};
         PC_TGT:    w = '{op: OP_MUL_TGT,   cond: C_NEXT,      target: PC_WAIT};
         PC_WB:     w = '{op: OP_REL_WB,    cond: C_ALWAYS,    target: PC_SCALE};
         PC_ATTACK: w = '{op: OP_ATTACK,    cond: C_NEXT,      target: PC_WAIT};
         PC_SCALE:  w = '{op: OP_SCALE_L,   cond: C_NEXT,      target: PC_WAIT};
         PC_SCALER: w = '{op: OP_SCALE_R,   cond: C_NEXT,      target: PC_WAIT};
         PC_EMIT:   w = '{op: OP_EMIT,      cond: C_OUT_FREE,  target: PC_WAIT};
         PC_RETRY:  w = '{op: OP_NOP,       cond: C_ALWAYS,    target: PC_EMIT};
         PC_UNITY:  w = '{op: OP_SET_UNITY, cond: C_ALWAYS,    target: PC_SCALE};
         default:   w = '{op: OP_NOP,       cond: C_ALWAYS,    target: PC_WAIT};
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/slp_ifs.sv
interface slp_req_if import slp_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [SampleW-1:0] left_in;
   logic signed [SampleW-1:0] right_in;
   logic                      block_end;

   modport source (output valid, left_in, right_in, block_end, input ready);
   modport sink   (input valid, left_in, right_in, block_end, output ready);
endinterface

interface slp_rsp_if import slp_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [SampleW-1:0] left_out;
   logic signed [SampleW-1:0] right_out;
   logic [GainW-1:0]          gain_out;
   logic                      block_end_out;

   modport source (output valid, left_out, right_out, gain_out, block_end_out, input ready);
   modport sink   (input valid, left_out, right_out, gain_out, block_end_out, output ready);
endinterface

// File: hw/rtl/stereo_peak_limiter.sv
// Channel   Direction  Handshake          Payload
// req_ch    in         valid / ready      left_in, right_in, block_end
// rsp_ch    out        valid / ready      left_out, right_out, gain_out, block_end_out
// csr_*     in         csr_we             csr_index, csr_wdata
//
// When the peak is over the threshold, an item passes through the 16-step restoring
// divider that forms threshold/peak, and the gain then drops at once or relaxes towards
// the target. Otherwise the divider is skipped, and with limiting off the gain update too.
// One item is worked on at a time; the next is taken while the last result waits.
// Reset restores unity gain and the register defaults; a stalled result keeps the control
// program circling between its emit and retry steps until the output register frees up.
module stereo_peak_limiter import slp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   slp_req_if.sink          req_ch,
   slp_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [IdxW-1:0]  csr_index,
   input  logic [CoefW-1:0] csr_wdata
);

   logic             limiter_on_ff, limiter_on_in;
   logic [CoefW-1:0] level_ff, level_in;
   logic [CoefW-1:0] release_ff, release_in;
   op_type           op;
   status_type       status;

   always_comb begin
      limiter_on_in = limiter_on_ff;
      level_in      = level_ff;
      release_in    = release_ff;
      if (csr_we) begin
         case (csr_index)
            REG_LIMITER_ON:    limiter_on_in = csr_wdata[0];
            REG_LIMIT_LEVEL: begin
               if (csr_wdata < LEVEL_MIN) begin
                  level_in = LEVEL_MIN;
               end else if (csr_wdata > LEVEL_MAX) begin
                  level_in = LEVEL_MAX;
               end else begin
                  level_in = csr_wdata;
               end
            end
            REG_RELEASE_COEFF: release_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limiter_on_ff <= 1'b0;
         level_ff      <= LEVEL_MAX;
         release_ff    <= REL_RESET;
      end else begin
         limiter_on_ff <= limiter_on_in;
         level_ff      <= level_in;
         release_ff    <= release_in;
      end
   end

   slp_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   slp_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .limiter_on    (limiter_on_ff),
      .limit_level   (level_ff),
      .release_coeff (release_ff),
      .req_valid     (req_ch.valid),
      .left_in       (req_ch.left_in),
      .right_in      (req_ch.right_in),
      .block_end     (req_ch.block_end),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .left_out      (rsp_ch.left_out),
      .right_out     (rsp_ch.right_out),
      .gain_out      (rsp_ch.gain_out),
      .block_end_out (rsp_ch.block_end_out),
      .status        (status)
   );

   // The item is taken only in the program's load step, and never during reset.
   assign req_ch.ready = (op == OP_LOAD) && !reset;

   a_leave_load: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("sequencer stayed in its load step after taking an item");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(!req_ch.ready))
      else $error("result appeared while the sequencer was waiting for input");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.gain_out <= GAIN_UNITY) && (rsp_ch.gain_out != '0))
      else $error("applied gain outside its range");

endmodule

// File: hw/rtl/slp_useq.sv
module slp_useq import slp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output op_type     op
);

   pc_type    pc_ff;
   pc_type    pc_in;
   uword_type word;
   logic      take;

   assign word = ucode(pc_ff);
   assign op   = word.op;

   always_comb begin
      case (word.cond)
         C_NEXT:      take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_NO_INPUT:  take = !status.in_valid;
         C_OFF:       take = status.limiter_off;
         C_NO_EXCEED: take = status.no_exceed;
         C_DIV_MORE:  take = status.div_more;
         C_ATTACK:    take = status.attack;
         C_OUT_FREE:  take = status.out_free;
         default:     take = 1'b0;
      endcase
      pc_in = take ? word.target : pc_ff + pc_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: hw/rtl/slp_dpath.sv
module slp_dpath import slp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  op_type                    op,
   input  logic                      limiter_on,
   input  logic [CoefW-1:0]          limit_level,
   input  logic [CoefW-1:0]          release_coeff,
   input  logic                      req_valid,
   input  logic signed [SampleW-1:0] left_in,
   input  logic signed [SampleW-1:0] right_in,
   input  logic                      block_end,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [SampleW-1:0] left_out,
   output logic signed [SampleW-1:0] right_out,
   output logic [GainW-1:0]          gain_out,
   output logic                      block_end_out,
   output status_type                status
);

   logic signed [SampleW-1:0] left_ff, left_ld_in, right_ff, right_ld_in;
   logic                      be_ff, be_in;
   logic [SampleW-1:0]        peak_ff, peak_in;
   logic [SampleW-1:0]        rem_ff, rem_in;
   logic [CoefW-1:0]          quot_ff, quot_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic [GainW-1:0]          gain_now_ff, gain_now_in;
   logic [GainW-1:0]          gmul_ff, gmul_in;
   logic signed [ProdW-1:0]   prod_ff, prod_in;
   logic signed [SampleW-1:0] lres_ff, lres_in;
   logic signed [SampleW-1:0] lo_ff, lo_in, ro_ff, ro_in;
   logic [GainW-1:0]          go_ff, go_in;
   logic                      beo_ff, beo_in;
   logic                      ov_ff, ov_in;

   logic [SampleW-1:0]        thr;
   logic [SampleW-1:0]        mag_l, mag_r;
   logic                      exceed;
   logic [GainW-1:0]          target;
   logic [SampleW:0]          div_sh, div_diff;
   logic                      div_ge;
   logic                      out_free;
   logic signed [SampleW-1:0] mul_a;
   logic signed [GainW:0]     mul_b;
   logic signed [ProdW-1:0]   product;

   assign thr      = {8'd0, limit_level, 8'd0};
   assign mag_l    = left_ff[SampleW-1] ? (~left_ff + 32'd1) : left_ff;
   assign mag_r    = right_ff[SampleW-1] ? (~right_ff + 32'd1) : right_ff;
   assign exceed   = peak_ff > thr;
   assign target   = exceed ? {1'b0, quot_ff} : GAIN_UNITY;
   // The remainder stays below the peak, so one spare bit covers the shift.
   assign div_sh   = {rem_ff, 1'b0};
   assign div_diff = div_sh - {1'b0, peak_ff};
   assign div_ge   = div_sh >= {1'b0, peak_ff};
   assign out_free = !ov_ff || rsp_ready;

   // One shared multiplier: sample by gain, or gain by release weight.
   always_comb begin
      case (op)
         OP_MUL_REL: begin
            mul_a = signed'({15'd0, gain_now_ff});
            mul_b = signed'({2'd0, release_coeff});
         end
         OP_MUL_TGT: begin
            mul_a = signed'({15'd0, target});
            mul_b = signed'({1'b0, GAIN_UNITY - {1'b0, release_coeff}});
         end
         OP_SCALE_R: begin
            mul_a = right_ff;
            mul_b = signed'({1'b0, gmul_ff});
         end
         default: begin
            mul_a = left_ff;
            mul_b = signed'({1'b0, gmul_ff});
         end
      endcase
   end

   assign product = mul_a * mul_b;

   always_comb begin
      left_ld_in  = left_ff;
      right_ld_in = right_ff;
      be_in       = be_ff;
      peak_in     = peak_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      cnt_in      = cnt_ff;
      gain_now_in = gain_now_ff;
      gmul_in     = gmul_ff;
      prod_in     = prod_ff;
      lres_in     = lres_ff;
      lo_in       = lo_ff;
      ro_in       = ro_ff;
      go_in       = go_ff;
      beo_in      = beo_ff;
      ov_in       = ov_ff && !rsp_ready;
      case (op)
         OP_LOAD: begin
            if (req_valid) begin
               left_ld_in  = left_in;
               right_ld_in = right_in;
               be_in       = block_end;
            end
         end
         OP_PEAK: begin
            peak_in = (mag_l > mag_r) ? mag_l : mag_r;
            rem_in  = thr;
            cnt_in  = '0;
         end
         OP_DIV_STEP: begin
            rem_in  = div_ge ? div_diff[SampleW-1:0] : div_sh[SampleW-1:0];
            quot_in = {quot_ff[CoefW-2:0], div_ge};
            cnt_in  = cnt_ff + CntW'(1);
         end
         OP_MUL_REL: begin
            prod_in = product;
         end
         OP_MUL_TGT: begin
            prod_in = prod_ff + product;
         end
         OP_REL_WB: begin
            gain_now_in = prod_ff[32:16];
            gmul_in     = prod_ff[32:16];
         end
         OP_ATTACK: begin
            gain_now_in = target;
            gmul_in     = target;
         end
         OP_SET_UNITY: begin
            gmul_in = GAIN_UNITY;
         end
         OP_SCALE_L: begin
            prod_in = product;
         end
         OP_SCALE_R: begin
            // An arithmetic shift of the product rounds toward minus infinity.
            lres_in = prod_ff[47:16];
            prod_in = product;
         end
         OP_EMIT: begin
            if (out_free) begin
               lo_in  = lres_ff;
               ro_in  = prod_ff[47:16];
               go_in  = gmul_ff;
               beo_in = be_ff;
               ov_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_ld_in;
      right_ff <= right_ld_in;
      be_ff    <= be_in;
      peak_ff  <= peak_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      cnt_ff   <= cnt_in;
      gmul_ff  <= gmul_in;
      prod_ff  <= prod_in;
      lres_ff  <= lres_in;
      lo_ff    <= lo_in;
      ro_ff    <= ro_in;
      go_ff    <= go_in;
      beo_ff   <= beo_in;
      if (reset) begin
         gain_now_ff <= GAIN_UNITY;
         ov_ff       <= 1'b0;
      end else begin
         gain_now_ff <= gain_now_in;
         ov_ff       <= ov_in;
      end
   end

   assign rsp_valid     = ov_ff;
   assign left_out      = lo_ff;
   assign right_out     = ro_ff;
   assign gain_out      = go_ff;
   assign block_end_out = beo_ff;

   assign status.in_valid    = req_valid;
   assign status.limiter_off = !limiter_on;
   assign status.no_exceed   = !exceed;
   assign status.div_more    = cnt_ff != CntW'(DivSteps - 1);
   assign status.attack      = target < gain_now_ff;
   assign status.out_free    = out_free;

endmodule
